[design/mclbb_pkg.sv]
// shared types and constants for the multi-channel linear byte buffer
// no dependencies; every other file of the block imports this package
package mclbb_pkg;

  localparam int CHANNELS   = 8;
  localparam int DEPTH      = 256;
  localparam int NUM_LIMITS = 8;

  localparam int CH_W       = 3;
  localparam int LIM_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W     = $clog2(CHANNELS * DEPTH);

  localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_LAST  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one access to the byte memory
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  // what the output stage needs to build the result item
  typedef struct packed {
    status_t           status;
    logic              from_mem;
    logic [BYTE_W-1:0] data;
  } result_t;

  // capacity of a channel, saturated at the memory depth
  function automatic logic [POS_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
    logic [POS_W-1:0] res;
    if (32'(lim) > DEPTH) res = POS_W'(DEPTH);
    else res = POS_W'(lim);
    return res;
  endfunction

  // flat byte address of a channel and position
  function automatic logic [ADDR_W-1:0] byte_addr(input logic [CH_W-1:0] ch,
                                                  input logic [POS_W-1:0] pos);
    return ADDR_W'(32'(ch) * DEPTH + 32'(pos));
  endfunction

endpackage

[design/mclbb_if.sv]
// valid/ready channel interfaces for the request and result items
// depends on mclbb_pkg
interface mclbb_in_if;
  import mclbb_pkg::*;

  logic              valid;
  logic              ready;
  action_t           action;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, action, channel, write_byte, input ready);
  modport sink   (input valid, action, channel, write_byte, output ready);
endinterface

interface mclbb_out_if;
  import mclbb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  status_t           status;

  modport source (output valid, read_byte, status, input ready);
  modport sink   (input valid, read_byte, status, output ready);
endinterface

[design/mclbb_byte_ram.sv]
// byte memory for all channels: one write or one read per cycle
// read data registered; depends on mclbb_pkg
module mclbb_byte_ram (
  input  logic                        clk,
  input  mclbb_pkg::mem_req_t         req,
  output logic [mclbb_pkg::BYTE_W-1:0] rd_data
);
  import mclbb_pkg::*;

  logic [BYTE_W-1:0] byte_mem_r [CHANNELS*DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      byte_mem_r[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= byte_mem_r[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/mclbb_pos_ctrl.sv]
// per-channel position registers, limit registers and the request decode
// produces the memory access and result info; depends on mclbb_pkg
module mclbb_pos_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mclbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mclbb_pkg::LIM_W-1:0]    cfg_data,
  input  logic                           accept,
  input  mclbb_pkg::action_t             action,
  input  logic [mclbb_pkg::CH_W-1:0]     channel,
  input  logic [mclbb_pkg::BYTE_W-1:0]   write_byte,
  output mclbb_pkg::mem_req_t            mem_req,
  output mclbb_pkg::result_t             result
);
  import mclbb_pkg::*;

  logic [LIM_W-1:0] limit_r [NUM_LIMITS];
  logic [POS_W-1:0] wr_pos_r [CHANNELS];
  logic [POS_W-1:0] rd_pos_r [CHANNELS];

  logic              ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [POS_W-1:0]  wp, rp, lim, rp_inc;
  logic [POS_W-1:0]  wr_pos_nxt, rd_pos_nxt;
  logic              upd;

  assign ch_ok  = (32'(channel) < CHANNELS) && (32'(channel) < NUM_LIMITS);
  assign ch_idx = CH_IDX_W'(channel);
  assign wp     = ch_ok ? wr_pos_r[ch_idx] : '0;
  assign rp     = ch_ok ? rd_pos_r[ch_idx] : '0;
  assign lim    = ch_ok ? eff_limit(limit_r[channel[CFG_IDX_W-1:0]]) : '0;
  assign rp_inc = rp + POS_W'(1);

  always_comb begin
    mem_req         = '0;
    mem_req.wdata   = write_byte;
    result.status   = ST_OK;
    result.from_mem = 1'b0;
    result.data     = '0;
    wr_pos_nxt      = wp;
    rd_pos_nxt      = rp;
    upd             = 1'b0;
    unique case (action)
      ACT_PUSH: begin
        if (ch_ok && (wp < lim)) begin
          mem_req.wr_en = accept;
          mem_req.addr  = byte_addr(channel, wp);
          result.data   = write_byte;
          wr_pos_nxt    = wp + POS_W'(1);
          upd           = 1'b1;
        end else begin
          result.status = ST_FULL;
        end
      end
      ACT_POP: begin
        if (ch_ok && (rp < wp)) begin
          mem_req.rd_en   = accept;
          mem_req.addr    = byte_addr(channel, rp);
          result.from_mem = 1'b1;
          upd             = 1'b1;
          // drained: both positions wrap to the start
          if (rp_inc == wp) begin
            wr_pos_nxt = '0;
            rd_pos_nxt = '0;
          end else begin
            rd_pos_nxt = rp_inc;
          end
        end else begin
          result.status = ST_EMPTY;
        end
      end
      ACT_FLUSH: begin
        wr_pos_nxt = '0;
        rd_pos_nxt = '0;
        upd        = ch_ok;
      end
      ACT_LAST: begin
        if (ch_ok && (wp != '0)) begin
          mem_req.rd_en   = accept;
          mem_req.addr    = byte_addr(channel, wp - POS_W'(1));
          result.from_mem = 1'b1;
        end else begin
          result.status = ST_EMPTY;
        end
      end
      default: begin
        result.status = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LIMITS; i++) limit_r[i] <= LIMIT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        wr_pos_r[i] <= '0;
        rd_pos_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (32'(cfg_index) < NUM_LIMITS)) begin
        limit_r[cfg_index] <= cfg_data;
      end
      if (accept && upd) begin
        wr_pos_r[ch_idx] <= wr_pos_nxt;
        rd_pos_r[ch_idx] <= rd_pos_nxt;
      end
    end
  end

endmodule

[design/multi_channel_linear_byte_buffer_core.sv]
// Eight independent byte buffers sharing one 2048-byte memory. Each request item
// (push, pop, flush or read-last) is decoded against the channel's positions,
// issues at most one memory access, and its result item appears in the cycle
// after acceptance from the output register. A new item is taken every
// cycle while the output register is empty or being emptied, so the sustained
// rate is one item per clock; the single memory port (one read or one write per
// item) sets that figure. No clearing pass follows reset: bytes are only read
// below a channel's write position, so unwritten memory is never observed.
// Limits are written through the cfg port, index 0..7 for channels 0..7.
// depends on mclbb_pkg, mclbb_if, mclbb_byte_ram, mclbb_pos_ctrl
module multi_channel_linear_byte_buffer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  mclbb_in_if.sink                        in_chan,
  mclbb_out_if.source                     out_chan,
  input  logic                            cfg_we,
  input  logic [mclbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mclbb_pkg::LIM_W-1:0]     cfg_data
);
  import mclbb_pkg::*;

  logic              accept;
  mem_req_t          mem_req;
  result_t           result;
  logic [BYTE_W-1:0] ram_q;

  // output register stage
  logic    out_valid_r;
  result_t res_r;

  // an item enters whenever the output slot is free or drains this cycle
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // positions update at the accepting edge, so the next item sees them;
  // a pop accepted right after a push reads the byte that the push wrote
  mclbb_pos_ctrl u_pos_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .action     (in_chan.action),
    .channel    (in_chan.channel),
    .write_byte (in_chan.write_byte),
    .mem_req    (mem_req),
    .result     (result)
  );

  // read data is only loaded on accept, so it holds while the output stalls
  mclbb_byte_ram u_byte_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= result;
    end
  end

  // popped and last bytes come from memory, echo and zero from the register
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = res_r.status;
  assign out_chan.read_byte = res_r.from_mem ? ram_q : res_r.data;

endmodule
